// ===== sv/roc_pkg.sv =====
// Package with the class codes, register indexes and reset values of the overlap classifier.
`default_nettype none

package roc_pkg;

    typedef enum logic [1:0] {
        CLASS_PROPER           = 2'd0,
        CLASS_QUERY_CONTAINED  = 2'd1,
        CLASS_TARGET_CONTAINED = 2'd2,
        CLASS_SHORT            = 2'd3
    } overlap_class_t;

    localparam int CFG_INDEX_BITS = 2;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_MAX_OVERHANG     = 2'd0;
    localparam cfg_index_t CFG_MIN_OVERLAP_SPAN = 2'd1;

    localparam int MAX_OVERHANG_RESET     = 1000;
    localparam int MIN_OVERLAP_SPAN_RESET = 2000;

endpackage

`default_nettype wire

// ===== sv/read_overlap_classifier_core.sv =====
// Read overlap classifier: overhangs, orientation, internal flag and class of one overlap record.
`default_nettype none

// An overlap record is taken whenever start is high; busy never rises, so a new record may
// be given in every cycle. Each record passes through three register stages (tails and
// spans, strand rules and clipped ends, extended spans with the final compares), and its
// result appears on the output ports, marked by done, as it leaves the third stage.
// The receiver cannot stall: each result is present for exactly one cycle. The two
// registers are written through cfg_we, cfg_index and cfg_wdata and should only change
// while no record is in flight.
module read_overlap_classifier_core
    import roc_pkg::*;
#(
    parameter int POSITION_BITS = 24
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       cfg_we,
    input  wire cfg_index_t                 cfg_index,
    input  wire logic [POSITION_BITS-1:0]   cfg_wdata,

    input  wire logic                       start,
    output      logic                       busy,
    input  wire logic [POSITION_BITS-1:0]   query_length,
    input  wire logic [POSITION_BITS-1:0]   query_start,
    input  wire logic [POSITION_BITS-1:0]   query_end,
    input  wire logic [POSITION_BITS-1:0]   target_length,
    input  wire logic [POSITION_BITS-1:0]   target_start,
    input  wire logic [POSITION_BITS-1:0]   target_end,
    input  wire logic                       reverse_strand,

    output      logic                       done,
    output      logic signed [POSITION_BITS:0] suffix_overhang,
    output      logic signed [POSITION_BITS:0] prefix_overhang,
    output      logic                       orientation_positive,
    output      logic                       internal_match,
    output      overlap_class_t             overlap_class
);

    localparam int P  = POSITION_BITS;
    localparam int W1 = P + 1;
    localparam int W2 = P + 2;
    localparam int WE = P + 5;

    localparam logic signed [W2-1:0] SAT_HI = {2'b00, {P{1'b1}}};
    localparam logic signed [W2-1:0] SAT_LO = -SAT_HI;

    // Configuration registers.
    logic [P-1:0] max_overhang_reg;
    logic [P-1:0] min_overlap_span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_overhang_reg     <= P'(MAX_OVERHANG_RESET);
            min_overlap_span_reg <= P'(MIN_OVERLAP_SPAN_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_OVERHANG:     max_overhang_reg     <= cfg_wdata;
                CFG_MIN_OVERLAP_SPAN: min_overlap_span_reg <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: tails and aligned spans.
    logic                 s1_valid_reg;
    logic                 s1_rev_reg;
    logic [P-1:0]         s1_qs_reg;
    logic [P-1:0]         s1_ts_reg;
    logic signed [W1-1:0] s1_qtail_reg;
    logic signed [W1-1:0] s1_ttail_reg;
    logic signed [W1-1:0] s1_qspan_reg;
    logic signed [W1-1:0] s1_tspan_reg;

    logic signed [W1-1:0] s1_qtail_next;
    logic signed [W1-1:0] s1_ttail_next;
    logic signed [W1-1:0] s1_qspan_next;
    logic signed [W1-1:0] s1_tspan_next;

    always_comb
    begin
        s1_qtail_next = $signed({1'b0, query_length})  - $signed({1'b0, query_end});
        s1_ttail_next = $signed({1'b0, target_length}) - $signed({1'b0, target_end});
        s1_qspan_next = $signed({1'b0, query_end})     - $signed({1'b0, query_start});
        s1_tspan_next = $signed({1'b0, target_end})    - $signed({1'b0, target_start});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_rev_reg   <= reverse_strand;
        s1_qs_reg    <= query_start;
        s1_ts_reg    <= target_start;
        s1_qtail_reg <= s1_qtail_next;
        s1_ttail_reg <= s1_ttail_next;
        s1_qspan_reg <= s1_qspan_next;
        s1_tspan_reg <= s1_tspan_next;
    end

    // Stage 2: strand rules, clipped end overhangs and containment compares.
    logic                 s2_valid_reg;
    logic signed [W2-1:0] s2_suffix_reg;
    logic signed [W2-1:0] s2_prefix_reg;
    logic                 s2_orient_reg;
    logic signed [W1-1:0] s2_ext5_reg;
    logic signed [W1-1:0] s2_ext3_reg;
    logic signed [W1-1:0] s2_qspan_reg;
    logic signed [W1-1:0] s2_tspan_reg;
    logic                 s2_qcont_reg;
    logic                 s2_tcont_reg;

    logic signed [W2-1:0] s2_suffix_next;
    logic signed [W2-1:0] s2_prefix_next;
    logic                 s2_orient_next;
    logic signed [W1-1:0] s2_ext5_next;
    logic signed [W1-1:0] s2_ext3_next;
    logic                 s2_qcont_next;
    logic                 s2_tcont_next;

    logic signed [W1-1:0] qs_s;
    logic signed [W1-1:0] ts_s;
    logic signed [W1-1:0] hang5;
    logic signed [W1-1:0] hang3;
    logic                 both_ends;

    always_comb
    begin
        qs_s      = $signed({1'b0, s1_qs_reg});
        ts_s      = $signed({1'b0, s1_ts_reg});
        both_ends = (qs_s > s1_qtail_reg) && (ts_s > s1_ttail_reg);

        if (!s1_rev_reg)
        begin
            if (s1_qs_reg > s1_ts_reg)
            begin
                s2_suffix_next = W2'(s1_ttail_reg) - W2'(s1_qtail_reg);
                s2_orient_next = 1'b1;
            end
            else
            begin
                s2_suffix_next = W2'(ts_s) - W2'(qs_s);
                s2_orient_next = 1'b0;
            end
            if (s1_qs_reg < s1_ts_reg)
            begin
                s2_prefix_next = W2'(s1_qtail_reg) - W2'(s1_ttail_reg);
            end
            else
            begin
                s2_prefix_next = W2'(qs_s) - W2'(ts_s);
            end
        end
        else if (both_ends)
        begin
            s2_suffix_next = W2'(ts_s) - W2'(s1_qtail_reg);
            s2_prefix_next = W2'(qs_s) - W2'(s1_ttail_reg);
            s2_orient_next = 1'b1;
        end
        else
        begin
            s2_suffix_next = W2'(s1_ttail_reg) - W2'(qs_s);
            s2_prefix_next = W2'(s1_qtail_reg) - W2'(ts_s);
            s2_orient_next = 1'b0;
        end

        hang5 = s1_rev_reg ? s1_ttail_reg : ts_s;
        hang3 = s1_rev_reg ? ts_s : s1_ttail_reg;

        s2_ext5_next  = (qs_s < hang5) ? qs_s : hang5;
        s2_ext3_next  = (s1_qtail_reg < hang3) ? s1_qtail_reg : hang3;
        s2_qcont_next = (qs_s <= hang5) && (s1_qtail_reg <= hang3);
        s2_tcont_next = (qs_s >= hang5) && (s1_qtail_reg >= hang3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_suffix_reg <= s2_suffix_next;
        s2_prefix_reg <= s2_prefix_next;
        s2_orient_reg <= s2_orient_next;
        s2_ext5_reg   <= s2_ext5_next;
        s2_ext3_reg   <= s2_ext3_next;
        s2_qspan_reg  <= s1_qspan_reg;
        s2_tspan_reg  <= s1_tspan_reg;
        s2_qcont_reg  <= s2_qcont_next;
        s2_tcont_reg  <= s2_tcont_next;
    end

    // Stage 3: extended spans, internal test, class and saturation.
    logic                 done_reg;
    logic signed [W1-1:0] suffix_reg;
    logic signed [W1-1:0] prefix_reg;
    logic                 orient_reg;
    logic                 internal_reg;
    overlap_class_t       class_reg;

    logic signed [WE-1:0] qext;
    logic signed [WE-1:0] text;
    logic signed [WE-1:0] qspan_x5;
    logic signed [WE-1:0] qext_x4;
    logic signed [WE-1:0] min_span_s;
    logic signed [W1-1:0] max_hang_s;
    logic                 internal_next;
    overlap_class_t       class_next;
    logic signed [W1-1:0] suffix_next;
    logic signed [W1-1:0] prefix_next;

    always_comb
    begin
        qext       = WE'(s2_qspan_reg) + WE'(s2_ext5_reg) + WE'(s2_ext3_reg);
        text       = WE'(s2_tspan_reg) + WE'(s2_ext5_reg) + WE'(s2_ext3_reg);
        qspan_x5   = (WE'(s2_qspan_reg) <<< 2) + WE'(s2_qspan_reg);
        qext_x4    = qext <<< 2;
        max_hang_s = $signed({1'b0, max_overhang_reg});
        min_span_s = $signed(WE'({1'b0, min_overlap_span_reg}));

        internal_next = (s2_ext5_reg > max_hang_s) || (s2_ext3_reg > max_hang_s)
                        || (qspan_x5 < qext_x4);

        if (internal_next)
        begin
            class_next = CLASS_PROPER;
        end
        else if (s2_qcont_reg)
        begin
            class_next = CLASS_QUERY_CONTAINED;
        end
        else if (s2_tcont_reg)
        begin
            class_next = CLASS_TARGET_CONTAINED;
        end
        else if ((qext < min_span_s) || (text < min_span_s))
        begin
            class_next = CLASS_SHORT;
        end
        else
        begin
            class_next = CLASS_PROPER;
        end

        if (s2_suffix_reg > SAT_HI)
        begin
            suffix_next = SAT_HI[W1-1:0];
        end
        else if (s2_suffix_reg < SAT_LO)
        begin
            suffix_next = SAT_LO[W1-1:0];
        end
        else
        begin
            suffix_next = s2_suffix_reg[W1-1:0];
        end

        if (s2_prefix_reg > SAT_HI)
        begin
            prefix_next = SAT_HI[W1-1:0];
        end
        else if (s2_prefix_reg < SAT_LO)
        begin
            prefix_next = SAT_LO[W1-1:0];
        end
        else
        begin
            prefix_next = s2_prefix_reg[W1-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        suffix_reg   <= suffix_next;
        prefix_reg   <= prefix_next;
        orient_reg   <= s2_orient_reg;
        internal_reg <= internal_next;
        class_reg    <= class_next;
    end

    assign done                 = done_reg;
    assign suffix_overhang      = suffix_reg;
    assign prefix_overhang      = prefix_reg;
    assign orientation_positive = orient_reg;
    assign internal_match       = internal_reg;
    assign overlap_class        = class_reg;

    // A result only follows a matching input transfer that has passed through every stage.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(start, 3))
        else $error("result without a matching input transfer");

    // An internal match always carries the proper/internal class.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && internal_match) |-> (overlap_class == CLASS_PROPER))
        else $error("internal match with a containment or short class");

    // Saturation never lets an overhang reach the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((suffix_overhang != {1'b1, {P{1'b0}}})
                  && (prefix_overhang != {1'b1, {P{1'b0}}})))
        else $error("overhang outside the saturated range");

endmodule

`default_nettype wire
